### rtl/xmt_pkg.sv
package xmt_pkg;

   // Event codes carried in the event_kind field of a result.
   typedef enum logic [3:0] {
      EV_CONTENT_BYTE = 4'd0,
      EV_CONTENT_END  = 4'd1,
      EV_TAG_BYTE     = 4'd2,
      EV_TAG_END      = 4'd3,
      EV_ATTR_BYTE    = 4'd4,
      EV_ATTR_END     = 4'd5,
      EV_VALUE_BYTE   = 4'd6,
      EV_VALUE_END    = 4'd7,
      EV_TAG_DONE     = 4'd8
   } event_kind_type;

   // One result event, without its end-of-run mark.
   typedef struct packed {
      logic           closing;
      logic [7:0]     data;
      event_kind_type kind;
   } event_type;

   // One queue entry holds all events that one input byte causes.
   typedef struct packed {
      logic      two_events;
      event_type ev1;
      event_type ev0;
   } queue_entry_type;

   // Status of the event queue as seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_QUOTE = 8'h22;

endpackage

### rtl/xmt_front.sv
module xmt_front
   import xmt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   output logic             in_ready,
   input  queue_status_type q_status,
   output logic             push,
   output queue_entry_type  push_entry
);

   // Parser states, one-hot.
   typedef enum logic [7:0] {
      ST_CONTENT    = 8'b0000_0001,
      ST_BEGIN      = 8'b0000_0010,
      ST_TAG_NAME   = 8'b0000_0100,
      ST_ATTR_WS    = 8'b0000_1000,
      ST_ATTR_NAME  = 8'b0001_0000,
      ST_WAIT_EQ    = 8'b0010_0000,
      ST_WAIT_QUOTE = 8'b0100_0000,
      ST_VALUE      = 8'b1000_0000
   } parse_state_type;

   parse_state_type state_ff, state_in;
   logic            closing_ff, closing_in;
   logic            seen_ff, seen_in;
   logic [1:0]      count;
   logic            accept;

   function automatic logic is_name_char(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
             b == 8'h2E || b == 8'h2D || b == 8'h5F || b == 8'h3A;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
   endfunction

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;

   // Run the byte through the parser; a byte that ends a name is examined
   // again in the next state, so up to four passes happen combinationally.
   always_comb begin
      parse_state_type st;
      logic            cl;
      logic            seen;
      logic            again;
      logic            emit;
      event_type       ev;
      st         = state_ff;
      cl         = closing_ff;
      seen       = seen_ff;
      again      = 1'b1;
      count      = 2'd0;
      push_entry = '0;
      for (int p = 0; p < 4; p++) begin
         emit = 1'b0;
         ev   = '0;
         if (again) begin
            again = 1'b0;
            unique case (st)
               ST_BEGIN: begin
                  st = ST_TAG_NAME;
                  if (in_byte == CH_SLASH) begin
                     cl = 1'b1;
                  end else begin
                     cl    = 1'b0;
                     again = 1'b1;
                  end
               end
               ST_TAG_NAME: begin
                  emit = 1'b1;
                  if (is_name_char(in_byte)) begin
                     ev.kind = EV_TAG_BYTE;
                     ev.data = to_lower(in_byte);
                  end else begin
                     ev.kind    = EV_TAG_END;
                     ev.closing = cl;
                     st         = ST_ATTR_WS;
                     again      = 1'b1;
                  end
               end
               ST_ATTR_WS: begin
                  if (in_byte == CH_GT) begin
                     emit       = 1'b1;
                     ev.kind    = EV_TAG_DONE;
                     ev.closing = cl;
                     st         = ST_CONTENT;
                     seen       = 1'b0;
                  end else if (in_byte == CH_SLASH) begin
                     emit       = 1'b1;
                     ev.kind    = EV_TAG_DONE;
                     ev.closing = cl;
                     cl         = 1'b1;
                  end else if (is_name_char(in_byte)) begin
                     st    = ST_ATTR_NAME;
                     again = 1'b1;
                  end
               end
               ST_ATTR_NAME: begin
                  emit = 1'b1;
                  if (is_name_char(in_byte)) begin
                     ev.kind = EV_ATTR_BYTE;
                     ev.data = to_lower(in_byte);
                  end else begin
                     ev.kind = EV_ATTR_END;
                     st      = ST_WAIT_EQ;
                     again   = 1'b1;
                  end
               end
               ST_WAIT_EQ: begin
                  if (in_byte == CH_EQ) begin
                     st = ST_WAIT_QUOTE;
                  end else if (!is_space(in_byte)) begin
                     st    = ST_ATTR_WS;
                     again = 1'b1;
                  end
               end
               ST_WAIT_QUOTE: begin
                  if (in_byte == CH_QUOTE) begin
                     st = ST_VALUE;
                  end else if (!is_space(in_byte)) begin
                     st    = ST_ATTR_WS;
                     again = 1'b1;
                  end
               end
               ST_VALUE: begin
                  emit = 1'b1;
                  if (in_byte == CH_QUOTE) begin
                     ev.kind = EV_VALUE_END;
                     st      = ST_ATTR_WS;
                  end else begin
                     ev.kind = EV_VALUE_BYTE;
                     ev.data = in_byte;
                  end
               end
               default: begin
                  // Content, and any code outside the state set.
                  if (in_byte == CH_LT) begin
                     if (seen) begin
                        emit    = 1'b1;
                        ev.kind = EV_CONTENT_END;
                     end
                     seen = 1'b0;
                     st   = ST_BEGIN;
                  end else begin
                     emit    = 1'b1;
                     ev.kind = EV_CONTENT_BYTE;
                     ev.data = in_byte;
                     seen    = 1'b1;
                     st      = ST_CONTENT;
                  end
               end
            endcase
         end
         // Keep at most two events per byte.
         if (emit) begin
            if (count == 2'd0) begin
               push_entry.ev0 = ev;
               count          = 2'd1;
            end else if (count == 2'd1) begin
               push_entry.ev1 = ev;
               count          = 2'd2;
            end
         end
      end
      push_entry.two_events = (count == 2'd2);
      state_in   = st;
      closing_in = cl;
      seen_in    = seen;
   end

   assign push = accept && (count != 2'd0);

   // Parser state advances on every input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CONTENT;
         closing_ff <= 1'b0;
         seen_ff    <= 1'b0;
      end else if (accept) begin
         state_ff   <= state_in;
         closing_ff <= closing_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

### rtl/xmt_queue.sv
module xmt_queue
   import xmt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_entry_type  push_entry,
   input  logic             pop,
   output queue_entry_type  head,
   output queue_status_type status
);

   queue_entry_type         entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]       count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/xmt_back.sv
module xmt_back
   import xmt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_entry_type  head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             phase,
   output logic             out_valid,
   input  logic             out_ready,
   output event_type        out_event,
   output logic             out_last
);

   logic      phase_ff, phase_in;
   logic      valid_ff, valid_in;
   event_type event_ff;
   logic      last_ff;
   logic      load;
   logic      sel_last;
   event_type sel_event;

   // Take the next event when the output register is free or drains now.
   assign load      = !q_status.empty && (!valid_ff || out_ready);
   assign sel_event = phase_ff ? head.ev1 : head.ev0;
   assign sel_last  = phase_ff || !head.two_events;
   assign pop       = load && sel_last;
   assign phase_in  = load ? !sel_last : phase_ff;
   assign valid_in  = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         event_ff <= sel_event;
         last_ff  <= sel_last;
      end
   end

   assign phase     = phase_ff;
   assign out_valid = valid_ff;
   assign out_event = event_ff;
   assign out_last  = last_ff;

endmodule

### rtl/xml_markup_tokenizer_top.sv
// Streaming XML tokenizer: one markup byte in, zero to two typed events out.
// Input channel req_: one byte per transfer in req_tdata.
// Result channel rsp_: one event per transfer; rsp_tlast marks the final
// event caused by one input byte. Bytes that cause no event give no transfer.
// The front parser classifies each byte in the cycle it arrives and writes
// its events as one entry into a four-entry queue; the back end drains the
// queue one event per cycle, while rsp_ is not stalled, into a registered output.
// The events of a byte pass through a queue entry and then the output register.
// Throughput: one byte per cycle while bytes cause at most one event and
// rsp_ does not stall; the output port moves one event per cycle, so a byte
// with two events needs an output transfer for each; the queue takes up the difference.
// A stall on rsp_ holds the output register; the queue fills and then
// req_tready falls until an entry is drained.
// Reset (synchronous, active high) returns the parser to content state,
// clears the closing and content flags and empties the queue.
module xml_markup_tokenizer_top
   import xmt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] event_kind, [11:4] event_byte, [12] closing
   output logic        rsp_tlast    // last_of_run
);

   queue_status_type q_status;
   queue_entry_type  push_entry;
   queue_entry_type  head;
   event_type        out_event;
   logic             push;
   logic             pop;
   logic             phase;

   xmt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_ready   (req_tready),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   xmt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   xmt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .phase     (phase),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_event (out_event),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_event};

   // The front never writes into a full queue.
   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("queue written while full");

   // The back never drains an empty queue.
   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue read while empty");

   // The second event of an entry is pending only for a two-event entry.
   a_phase_two : assert property (@(posedge clock) disable iff (reset)
      phase |-> (!q_status.empty && head.two_events))
      else $error("second event pending without a two-event entry");

   // After the first event of a pair is taken, its second follows with no gap in rsp_tvalid.
   a_second_follows : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("first event of a pair not followed by the second");

endmodule

### dv/xml_markup_tokenizer_top_tb.sv
`timescale 1ns / 100ps

module xml_markup_tokenizer_top_tb
   import xmt_pkg::*;
();

   // Parser states of the tokenizer as tracked on the testbench side.
   typedef enum logic [3:0] {
      PS_CONTENT    = 4'd0,
      PS_BEGIN      = 4'd1,
      PS_TAG_NAME   = 4'd2,
      PS_ATTR_WS    = 4'd3,
      PS_ATTR_NAME  = 4'd4,
      PS_WAIT_EQ    = 4'd5,
      PS_WAIT_QUOTE = 4'd6,
      PS_VALUE      = 4'd7
   } scan_state_type;

   // Ready patterns of the result side.
   typedef enum int {
      RX_ALWAYS,
      RX_COIN,
      RX_MOSTLY,
      RX_CADENCE
   } rx_mode_type;

   // One token event as it leaves the block.
   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     data;
      logic           closing;
      logic           last;
   } token_type;

   // One input byte, with its tokens typed in where they are obvious.
   typedef struct {
      logic [7:0] data;
      int         n_typed;
      token_type  tok0;
      token_type  tok1;
   } byte_row_type;

   localparam int        PREDICTED    = -1;
   localparam int        CYCLE_LIMIT  = 400000;
   localparam int        RANDOM_BYTES = 1900;
   localparam int        TAIL_CYCLES  = 16;
   localparam token_type NO_TOKEN     = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [3:0] event_kind, [11:4] event_byte, [12] closing
   logic        rsp_tlast;            // last_of_run

   // Predictor state.
   scan_state_type scan_state = PS_CONTENT;
   logic           tag_closing = 1'b0;
   logic           text_pending = 1'b0;
   token_type      predicted_tokens [2];

   token_type      pending_tokens [$];
   byte_row_type   byte_rows [$];
   int             n_directed;
   int             error_count = 0;
   int             cycle_count = 0;

   // Receiver pattern state.
   rx_mode_type rx_mode = RX_ALWAYS;
   int          rx_mode_left = 0;
   int          rx_tick = 0;
   int          rx_hold_left = 0;

   xml_markup_tokenizer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Character classes of the markup grammar.
   function automatic logic is_name_byte(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             b == "." || b == "-" || b == "_" || b == ":";
   endfunction

   function automatic logic is_white_byte(input logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      return (b >= "A" && b <= "Z") ? 8'(b + 8'd32) : b;
   endfunction

   function automatic token_type tk(input event_kind_type k, input logic [7:0] d,
                                    input logic c);
      return '{kind: k, data: d, closing: c, last: 1'b0};
   endfunction

   function automatic byte_row_type make_row(input logic [7:0] b, input int n,
                                             input token_type t0, input token_type t1);
      return '{data: b, n_typed: n, tok0: t0, tok1: t1};
   endfunction

   task automatic record_token(input event_kind_type k, input logic [7:0] d,
                               input logic c, inout int count);
      if (count < 2) begin
         predicted_tokens[count] = tk(k, d, c);
         count++;
      end
   endtask

   // Runs one byte through the tokenizer state machine. A byte that ends a
   // name is looked at again in the state that follows, so one byte may
   // pass through up to four states.
   task automatic tokenize_byte(input logic [7:0] b, output int count);
      logic again;
      count = 0;
      again = 1'b1;
      for (int pass = 0; pass < 4 && again; pass++) begin
         again = 1'b0;
         case (scan_state)
            PS_BEGIN: begin
               scan_state = PS_TAG_NAME;
               if (b == CH_SLASH) begin
                  tag_closing = 1'b1;
               end else begin
                  tag_closing = 1'b0;
                  again = 1'b1;
               end
            end
            PS_TAG_NAME: begin
               if (is_name_byte(b)) begin
                  record_token(EV_TAG_BYTE, fold_case(b), 1'b0, count);
               end else begin
                  record_token(EV_TAG_END, 8'h00, tag_closing, count);
                  scan_state = PS_ATTR_WS;
                  again = 1'b1;
               end
            end
            PS_ATTR_WS: begin
               if (b == CH_GT) begin
                  record_token(EV_TAG_DONE, 8'h00, tag_closing, count);
                  scan_state = PS_CONTENT;
                  text_pending = 1'b0;
               end else if (b == CH_SLASH) begin
                  record_token(EV_TAG_DONE, 8'h00, tag_closing, count);
                  tag_closing = 1'b1;
               end else if (is_name_byte(b)) begin
                  scan_state = PS_ATTR_NAME;
                  again = 1'b1;
               end
            end
            PS_ATTR_NAME: begin
               if (is_name_byte(b)) begin
                  record_token(EV_ATTR_BYTE, fold_case(b), 1'b0, count);
               end else begin
                  record_token(EV_ATTR_END, 8'h00, 1'b0, count);
                  scan_state = PS_WAIT_EQ;
                  again = 1'b1;
               end
            end
            PS_WAIT_EQ: begin
               if (b == CH_EQ) begin
                  scan_state = PS_WAIT_QUOTE;
               end else if (!is_white_byte(b)) begin
                  scan_state = PS_ATTR_WS;
                  again = 1'b1;
               end
            end
            PS_WAIT_QUOTE: begin
               if (b == CH_QUOTE) begin
                  scan_state = PS_VALUE;
               end else if (!is_white_byte(b)) begin
                  scan_state = PS_ATTR_WS;
                  again = 1'b1;
               end
            end
            PS_VALUE: begin
               if (b == CH_QUOTE) begin
                  record_token(EV_VALUE_END, 8'h00, 1'b0, count);
                  scan_state = PS_ATTR_WS;
               end else begin
                  record_token(EV_VALUE_BYTE, b, 1'b0, count);
               end
            end
            default: begin
               if (b == CH_LT) begin
                  if (text_pending) begin
                     record_token(EV_CONTENT_END, 8'h00, 1'b0, count);
                  end
                  text_pending = 1'b0;
                  scan_state = PS_BEGIN;
               end else begin
                  record_token(EV_CONTENT_BYTE, b, 1'b0, count);
                  text_pending = 1'b1;
                  scan_state = PS_CONTENT;
               end
            end
         endcase
      end
   endtask

   // Helpers that build the random markup stream.
   function automatic logic [7:0] name_char();
      int r;
      r = $urandom_range(0, 55);
      if (r < 26) begin
         return 8'(8'h41 + r);
      end else if (r < 52) begin
         return 8'(8'h61 + r - 26);
      end
      case (r)
         52:      return ".";
         53:      return "-";
         54:      return "_";
         default: return ":";
      endcase
   endfunction

   function automatic logic [7:0] raw_byte_except(input logic [7:0] barred);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == barred);
      return b;
   endfunction

   task automatic add_byte(input logic [7:0] b);
      byte_rows.push_back(make_row(b, PREDICTED, NO_TOKEN, NO_TOKEN));
   endtask

   task automatic add_name(input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) add_byte(name_char());
   endtask

   task automatic add_spaces(input int lo, input int hi);
      int r;
      repeat ($urandom_range(lo, hi)) begin
         r = $urandom_range(8, 13);
         add_byte(r == 8 ? 8'h20 : 8'(r));
      end
   endtask

   task automatic add_quoted_value();
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 8)) add_byte(raw_byte_except(CH_QUOTE));
      add_byte(CH_QUOTE);
   endtask

   // An opening tag with attributes; a broken tag mixes in attributes
   // without a value, unquoted values, a missing '=' and stray bytes.
   task automatic add_open_tag(input logic broken);
      logic [7:0] junk;
      add_byte(CH_LT);
      add_name(0, 6);
      repeat ($urandom_range(0, 3)) begin
         add_spaces(1, 2);
         add_name(1, 5);
         if (!broken) begin
            add_spaces(0, 1);
            add_byte(CH_EQ);
            add_spaces(0, 1);
            add_quoted_value();
         end else begin
            case ($urandom_range(0, 3))
               0: ;
               1: begin
                  add_byte(CH_EQ);
                  add_name(1, 4);
               end
               2: begin
                  add_spaces(1, 1);
                  add_quoted_value();
               end
               default: begin
                  add_spaces(1, 1);
                  do junk = 8'($urandom_range(0, 255));
                  while (is_name_byte(junk) || junk == CH_GT || junk == CH_SLASH ||
                         junk == CH_QUOTE);
                  add_byte(junk);
               end
            endcase
         end
      end
      add_spaces(0, 1);
      if ($urandom_range(0, 4) == 0) add_byte(CH_SLASH);
      add_byte(CH_GT);
   endtask

   // Random stream: mostly well-formed markup with random content, the
   // rest broken tags and raw noise.
   task automatic build_random_stream();
      int r;
      while (byte_rows.size() < n_directed + RANDOM_BYTES) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            repeat ($urandom_range(0, 10)) add_byte(raw_byte_except(CH_LT));
         end else if (r < 60) begin
            add_open_tag(1'b0);
         end else if (r < 72) begin
            add_byte(CH_LT);
            add_byte(CH_SLASH);
            add_name(1, 6);
            add_spaces(0, 1);
            add_byte(CH_GT);
         end else if (r < 85) begin
            add_open_tag(1'b1);
         end else if (r < 90) begin
            add_byte(CH_LT);
            if ($urandom_range(0, 1)) add_byte(CH_SLASH);
            if ($urandom_range(0, 1)) add_byte(CH_SLASH);
            add_byte(CH_GT);
         end else begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Sender: directed table first, then the random stream, in bursts.
   initial begin : req_side
      int        burst_left;
      int        gap;
      int        count;
      logic      drain;
      token_type t;

      // After reset: '<' with no content, then an empty tag name.
      byte_rows.push_back(make_row(CH_LT, 0, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row(CH_GT, 2, tk(EV_TAG_END, 8'h00, 1'b0),
                                   tk(EV_TAG_DONE, 8'h00, 1'b0)));
      // Content bytes at the extremes, then content end.
      byte_rows.push_back(make_row(8'h00, 1, tk(EV_CONTENT_BYTE, 8'h00, 1'b0), NO_TOKEN));
      byte_rows.push_back(make_row(8'hFF, 1, tk(EV_CONTENT_BYTE, 8'hFF, 1'b0), NO_TOKEN));
      byte_rows.push_back(make_row(CH_LT, 1, tk(EV_CONTENT_END, 8'h00, 1'b0), NO_TOKEN));
      // Tag name in upper case, one quoted attribute with extreme value bytes.
      byte_rows.push_back(make_row("A", PREDICTED, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row("Z", PREDICTED, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row(" ", PREDICTED, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row("X", PREDICTED, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row(CH_EQ, PREDICTED, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row(CH_QUOTE, 0, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row(8'hFF, 1, tk(EV_VALUE_BYTE, 8'hFF, 1'b0), NO_TOKEN));
      byte_rows.push_back(make_row(8'h00, 1, tk(EV_VALUE_BYTE, 8'h00, 1'b0), NO_TOKEN));
      byte_rows.push_back(make_row(CH_QUOTE, 1, tk(EV_VALUE_END, 8'h00, 1'b0), NO_TOKEN));
      // Stray byte between attributes is ignored.
      byte_rows.push_back(make_row("#", 0, NO_TOKEN, NO_TOKEN));
      // Attribute with a missing '=', then an unquoted value.
      byte_rows.push_back(make_row("b", PREDICTED, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row(" ", PREDICTED, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row("c", PREDICTED, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row(CH_EQ, PREDICTED, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row("v", PREDICTED, NO_TOKEN, NO_TOKEN));
      // Slash inside the tag reports it done, then '>' reports it again.
      byte_rows.push_back(make_row(CH_SLASH, PREDICTED, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row(CH_GT, 1, tk(EV_TAG_DONE, 8'h00, 1'b1), NO_TOKEN));
      // Closing tag.
      byte_rows.push_back(make_row(CH_LT, 0, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row(CH_SLASH, 0, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row("_", PREDICTED, NO_TOKEN, NO_TOKEN));
      byte_rows.push_back(make_row(CH_GT, 2, tk(EV_TAG_END, 8'h00, 1'b1),
                                   tk(EV_TAG_DONE, 8'h00, 1'b1)));
      n_directed = byte_rows.size();
      build_random_stream();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      burst_left = 0;
      foreach (byte_rows[i]) begin
         gap = 0;
         // Let the block run dry after the directed part and mid-stream.
         drain = (i == n_directed) || (i == n_directed + RANDOM_BYTES / 2);
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
         burst_left--;
         if (gap > 0 || drain) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
            if (drain) begin
               do @(posedge clock); while (pending_tokens.size() != 0);
            end
         end
         req_tvalid <= 1'b1;
         req_tdata  <= byte_rows[i].data;
         do @(posedge clock); while (!req_tready);

         // A typed row replaces the predicted tokens; the predictor still
         // advances its state on every byte.
         tokenize_byte(byte_rows[i].data, count);
         if (byte_rows[i].n_typed != PREDICTED) begin
            count = byte_rows[i].n_typed;
            predicted_tokens[0] = byte_rows[i].tok0;
            predicted_tokens[1] = byte_rows[i].tok1;
         end
         for (int k = 0; k < count; k++) begin
            t = predicted_tokens[k];
            t.last = (k == count - 1);
            pending_tokens.push_back(t);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("xml_markup_tokenizer_top verification clean");
      end else begin
         $display("xml_markup_tokenizer_top verification failed");
      end
      $finish;
   end

   // Receiver: changes its ready pattern now and then, and twice holds off
   // for a long stretch so that the block backs up into its input.
   always @(posedge clock) begin
      rx_tick++;
      if (rx_tick == 600 || rx_tick == 4000) rx_hold_left = 300;
      if (rx_mode_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(16, 200);
      end else begin
         rx_mode_left--;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: rsp_tready <= ($urandom_range(0, 9) != 0);
            default:   rsp_tready <= (rx_tick % 3 != 0);
         endcase
      end
   end

   // Compare each result transfer with the oldest pending token.
   always @(posedge clock) begin : check_tokens
      token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tokens.size() == 0) begin
            $error("unexpected event: event_kind %0d, event_byte %02h",
                   rsp_tdata[3:0], rsp_tdata[11:4]);
            error_count++;
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_tdata[3:0] !== want.kind) begin
               $error("event_kind mismatch: expected %0d, actual %0d",
                      want.kind, rsp_tdata[3:0]);
               error_count++;
            end
            if (rsp_tdata[11:4] !== want.data) begin
               $error("event_byte mismatch: expected %02h, actual %02h",
                      want.data, rsp_tdata[11:4]);
               error_count++;
            end
            if (rsp_tdata[12] !== want.closing) begin
               $error("closing mismatch: expected %0b, actual %0b",
                      want.closing, rsp_tdata[12]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run mismatch: expected %0b, actual %0b",
                      want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("xml_markup_tokenizer_top verification failed");
         $finish;
      end
   end

endmodule
